// File: rtl/color_run_blob_tracker_unit_defines.svh
// Assertion macros used by the blob tracker top level.
`ifndef COLOR_RUN_BLOB_TRACKER_UNIT_DEFINES_SVH
`define COLOR_RUN_BLOB_TRACKER_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/crb_pkg.sv
// Package with types and constants of the blob tracker.
`timescale 1ns / 1ps
`default_nettype none
package crb_pkg;
  localparam int unsigned MaxObjectsDefault = 4;
  localparam int unsigned CoordW = 10;
  localparam int unsigned ColorW = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegLineWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLinesPerFrame = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinRunWidth = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinHeight = 2'd3;

  localparam logic [ByteW-1:0] PktHeader = 8'h0A;
  localparam logic [ByteW-1:0] PktTerm   = 8'hFF;
  localparam logic [ByteW-1:0] LowEscape = 8'hFE;

  localparam logic [CoordW-1:0] LineWidthReset = 10'd176;
  localparam logic [CoordW-1:0] LinesPerFrameReset = 10'd480;
  localparam logic [7:0] MinRunReset = 8'd3;
  localparam logic [7:0] MinHeightReset = 8'd3;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic clear;      // clear table, line index and run start
    logic latch;      // capture the accepted item
    logic match;      // process the run against the table
    logic end_line;   // advance line counter, wrap to zero at frame end
    logic filter;     // drop stale short objects
    logic clr_table;  // clear table only (frame end)
    logic rpt_start;  // reset report slot and byte pointer
    logic rpt_next;   // advance report byte pointer
  } crb_cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic backward;
    logic line_done;
    logic do_filter;
    logic frame_done;
    logic count_zero;
    logic rpt_done;
  } crb_stat_t;

  function automatic logic [2:0] color_code(input logic [ColorW-1:0] c);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (c == (8'h80 >> i)) k = 3'(i);
    end
    return k;
  endfunction

  function automatic logic [ByteW-1:0] lo_byte(input logic [CoordW-1:0] v);
    logic [ByteW-1:0] b;
    b = v[ByteW-1:0];
    return (b == 8'hFF) ? LowEscape : b;
  endfunction
endpackage
`default_nettype wire

// File: rtl/crb_ctrl.sv
// Controller state machine of the blob tracker.
`timescale 1ns / 1ps
`default_nettype none
module crb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid,
  input  wire logic            req_type_i,
  output logic                 in_stall,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output crb_pkg::crb_cmd_t    cmd_o,
  input  wire crb_pkg::crb_stat_t stat_i
);
  import crb_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMatch = 3'd1;
  localparam logic [2:0] StLine = 3'd2;
  localparam logic [2:0] StFrame = 3'd3;
  localparam logic [2:0] StReport = 3'd4;

  logic [2:0] state_q, state_d;
  logic acc;

  assign in_stall = (state_q != StIdle);
  assign acc = in_valid && !in_stall;
  assign out_valid = (state_q == StReport);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (req_type_i) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            state_d = StMatch;
          end
        end
      end
      StMatch: begin
        if (stat_i.backward) begin
          state_d = StIdle;
        end else begin
          cmd_o.match = 1'b1;
          state_d = stat_i.line_done ? StLine : StIdle;
        end
      end
      StLine: begin
        cmd_o.filter = stat_i.do_filter;
        state_d = StFrame;
      end
      StFrame: begin
        cmd_o.end_line = 1'b1;
        if (stat_i.frame_done) begin
          if (stat_i.count_zero) begin
            cmd_o.clr_table = 1'b1;
            state_d = StIdle;
          end else begin
            cmd_o.rpt_start = 1'b1;
            state_d = StReport;
          end
        end else begin
          state_d = StIdle;
        end
      end
      StReport: begin
        if (!out_stall) begin
          if (stat_i.rpt_done) begin
            cmd_o.clr_table = 1'b1;
            state_d = StIdle;
          end else begin
            cmd_o.rpt_next = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/crb_datapath.sv
// Object table, line tracking and report byte generation.
`timescale 1ns / 1ps
`default_nettype none
module crb_datapath #(
  parameter int unsigned MaxObjects = crb_pkg::MaxObjectsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [crb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic [crb_pkg::ColorW-1:0]   color_mask_i,
  input  wire logic [crb_pkg::CoordW-1:0]   run_end_i,
  input  wire crb_pkg::crb_cmd_t            cmd_i,
  output crb_pkg::crb_stat_t                stat_o,
  output logic [crb_pkg::ByteW-1:0]         report_byte_o,
  output logic                              report_last_o
);
  import crb_pkg::*;

  localparam int unsigned SlotW = (MaxObjects > 1) ? $clog2(MaxObjects) : 1;
  localparam int unsigned CntW = $clog2(MaxObjects + 1);

  logic [CoordW-1:0] line_width_q, lines_per_frame_q;
  logic [7:0] min_run_q, min_height_q;

  logic [ColorW-1:0] col_q [MaxObjects];
  logic [CoordW-1:0] ps_q [MaxObjects];
  logic [CoordW-1:0] pe_q [MaxObjects];
  logic [CoordW-1:0] lft_q [MaxObjects];
  logic [CoordW-1:0] top_q [MaxObjects];
  logic [CoordW-1:0] rgt_q [MaxObjects];
  logic [CoordW-1:0] bot_q [MaxObjects];
  logic [MaxObjects-1:0] vld_q;
  logic [CntW-1:0] cnt_q;
  logic [CoordW-1:0] line_q, start_q;
  logic [ColorW-1:0] color_q;
  logic [CoordW-1:0] end_q;

  logic [SlotW-1:0] slot_q;
  logic [3:0] bpos_q;  // 0 header, 1 count, 2..10 object bytes, 11 terminator

  // Run evaluation.
  logic [CoordW-1:0] len;
  logic counted;
  logic [MaxObjects-1:0] hit, free;
  logic [MaxObjects-1:0] hit_sel, free_sel;
  logic any_hit, any_free;
  logic [CoordW-1:0] prev_line;

  assign len = end_q - start_q;
  assign counted = (color_q != '0) && (len > CoordW'(min_run_q));
  assign prev_line = line_q - 1'b1;

  always_comb begin
    logic found, ffound;
    found = 1'b0;
    ffound = 1'b0;
    hit_sel = '0;
    free_sel = '0;
    for (int i = 0; i < MaxObjects; i++) begin
      hit[i] = vld_q[i] && (col_q[i] == color_q) && (line_q != '0) &&
               (bot_q[i] == prev_line) &&
               ((start_q >= ps_q[i] && start_q <= pe_q[i]) ||
                (end_q >= ps_q[i] && end_q <= pe_q[i]) ||
                (start_q <= ps_q[i] && end_q >= pe_q[i]));
      free[i] = !vld_q[i];
      if (hit[i] && !found) begin
        hit_sel[i] = 1'b1;
        found = 1'b1;
      end
      if (free[i] && !ffound) begin
        free_sel[i] = 1'b1;
        ffound = 1'b1;
      end
    end
  end
  assign any_hit = |hit;
  assign any_free = |free && (cnt_q < CntW'(MaxObjects));

  logic [MaxObjects-1:0] stale;
  always_comb begin
    for (int i = 0; i < MaxObjects; i++) begin
      stale[i] = vld_q[i] && (bot_q[i] >= top_q[i]) &&
                 ((bot_q[i] - top_q[i]) < CoordW'(min_height_q)) &&
                 ((line_q < bot_q[i]) || ((line_q - bot_q[i]) > CoordW'(2)));
    end
  end

  assign stat_o.backward = end_q < start_q;
  assign stat_o.line_done = end_q >= line_width_q;
  assign stat_o.do_filter = (line_q[2:0] == 3'b111);
  assign stat_o.frame_done = ({1'b0, line_q} + 11'd1) >= {1'b0, lines_per_frame_q};
  assign stat_o.count_zero = (cnt_q == '0);
  assign stat_o.rpt_done = (bpos_q == 4'd11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      lines_per_frame_q <= LinesPerFrameReset;
      min_run_q <= MinRunReset;
      min_height_q <= MinHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLineWidth: line_width_q <= cfg_data_i;
        RegLinesPerFrame: lines_per_frame_q <= cfg_data_i;
        RegMinRunWidth: min_run_q <= cfg_data_i[7:0];
        RegMinHeight: min_height_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      color_q <= color_mask_i;
      end_q <= run_end_i;
    end
    for (int i = 0; i < MaxObjects; i++) begin
      if (cmd_i.clear || cmd_i.clr_table) begin
        col_q[i] <= '0; ps_q[i] <= '0; pe_q[i] <= '0;
        lft_q[i] <= '0; top_q[i] <= '0; rgt_q[i] <= '0; bot_q[i] <= '0;
      end else if (cmd_i.match && counted) begin
        if (any_hit && hit_sel[i]) begin
          ps_q[i] <= start_q;
          pe_q[i] <= end_q;
          if (lft_q[i] > start_q) lft_q[i] <= start_q;
          if (rgt_q[i] < end_q) rgt_q[i] <= end_q;
          bot_q[i] <= line_q;
        end else if (!any_hit && any_free && free_sel[i]) begin
          col_q[i] <= color_q;
          ps_q[i] <= start_q; pe_q[i] <= end_q;
          lft_q[i] <= start_q; rgt_q[i] <= end_q;
          top_q[i] <= line_q; bot_q[i] <= line_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
      line_q <= '0;
      start_q <= '0;
      slot_q <= '0;
      bpos_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        vld_q <= '0;
        cnt_q <= '0;
        line_q <= '0;
        start_q <= '0;
      end else begin
        if (cmd_i.match) begin
          if (counted && !any_hit && any_free) begin
            vld_q <= vld_q | free_sel;
            cnt_q <= cnt_q + 1'b1;
          end
          start_q <= stat_o.line_done ? '0 : end_q;
        end
        if (cmd_i.filter) begin
          vld_q <= vld_q & ~stale;
          cnt_q <= cnt_q - CntW'($countones(stale));
        end
        if (cmd_i.end_line) begin
          line_q <= stat_o.frame_done ? '0 : line_q + 1'b1;
        end
        if (cmd_i.clr_table) begin
          vld_q <= '0;
          cnt_q <= '0;
        end
      end
      if (cmd_i.rpt_start) begin
        bpos_q <= '0;
        slot_q <= '0;
      end else if (cmd_i.rpt_next) begin
        if (bpos_q == 4'd1 || bpos_q == 4'd10) begin
          // Seek the first valid slot after the count byte, else the next valid slot; if none, the terminator.
          logic [SlotW:0] s;
          logic got;
          s = (bpos_q == 4'd1) ? '0 : {1'b0, slot_q} + 1'b1;
          got = 1'b0;
          for (int i = 0; i < MaxObjects; i++) begin
            if (!got && (SlotW+1)'(i) >= s && vld_q[i]) begin
              slot_q <= SlotW'(i);
              got = 1'b1;
            end
          end
          bpos_q <= got ? 4'd2 : 4'd11;
        end else begin
          bpos_q <= bpos_q + 1'b1;
        end
      end
    end
  end

  logic [CoordW-1:0] coord;
  always_comb begin
    unique case (bpos_q)
      4'd3, 4'd4: coord = lft_q[slot_q];
      4'd5, 4'd6: coord = top_q[slot_q];
      4'd7, 4'd8: coord = rgt_q[slot_q];
      default: coord = bot_q[slot_q];
    endcase
  end

  always_comb begin
    report_last_o = 1'b0;
    unique case (bpos_q)
      4'd0: report_byte_o = PktHeader;
      4'd1: report_byte_o = ByteW'(cnt_q);
      4'd2: report_byte_o = {5'd0, color_code(col_q[slot_q])};
      4'd3, 4'd5, 4'd7, 4'd9: report_byte_o = {6'd0, coord[CoordW-1:8]};
      4'd4, 4'd6, 4'd8, 4'd10: report_byte_o = lo_byte(coord);
      default: begin
        report_byte_o = PktTerm;
        report_last_o = 1'b1;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/color_run_blob_tracker_unit.sv
// Top level of the colour run blob tracker.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | in_valid / in_stall  | req_type_i, color_mask_i, run_end_i
//  output   | out_valid / out_stall| report_byte_o, report_last_o
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A restart is done in its accept cycle. A run inside its line is accepted, then
// matched against all slots in parallel in a table update. A run that ends a
// line passes accept, table update, stale filter, line or frame bookkeeping;
// the input stalls until that work is done. At frame end, unless the table is
// empty, the report follows, one byte per cycle while out_stall stays low, and
// the table is cleared once the terminator byte is taken. Reset leaves the table empty and defaults set.
`timescale 1ns / 1ps
`default_nettype none
`include "color_run_blob_tracker_unit_defines.svh"
module color_run_blob_tracker_unit #(
  parameter int unsigned MaxObjects = crb_pkg::MaxObjectsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [crb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         req_type_i,
  input  wire logic [crb_pkg::ColorW-1:0]   color_mask_i,
  input  wire logic [crb_pkg::CoordW-1:0]   run_end_i,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [crb_pkg::ByteW-1:0]         report_byte_o,
  output logic                              report_last_o
);
  import crb_pkg::*;

  crb_cmd_t cmd;
  crb_stat_t stat;

  crb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .req_type_i, .in_stall,
    .out_stall, .out_valid, .cmd_o(cmd), .stat_i(stat)
  );

  crb_datapath #(.MaxObjects(MaxObjects)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .color_mask_i, .run_end_i, .cmd_i(cmd), .stat_o(stat),
    .report_byte_o, .report_last_o
  );

  // The controller never accepts an item while a report is being sent.
  `CRB_ASSERT_IMP(a_no_accept_in_report, clk_i, rst_ni, out_valid, in_stall)
  // A taken terminator byte returns the block to accepting items.
  `CRB_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni,
                   out_valid && !out_stall && report_last_o, !out_valid && !in_stall)
endmodule
`default_nettype wire
